### rtl/core/dwl_pkg.sv
// shared types and constants of the dictionary word lookup block
package dwl_pkg;

   // fixed field widths of the request beat
   localparam int NODE_W = 12;
   localparam int SYM_W  = 5;
   localparam int CMD_W  = 2;

   // largest node count and alphabet that the field widths can address
   localparam int NODE_LIMIT = 1 << NODE_W;
   localparam int SYM_LIMIT  = 1 << SYM_W;

   // request command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_EDGE   = 2'd0,
      CMD_MARK   = 2'd1,
      CMD_LETTER = 2'd2,
      CMD_QUERY  = 2'd3
   } cmd_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear_en;        // clearing pass writes zero at the sweep address
      logic edge_wr;         // write one transition from the request beat
      logic mark_wr;         // write one terminal mark from the request beat
      logic edge_rd;         // read the edge of the current node for the letter
      logic term_rd;         // read the terminal mark of the final node
      logic term_from_edge;  // terminal read address comes from edge read data
      logic take_edge;       // follow the edge that was just read
      logic reject;          // mark the word as rejected
      logic load_result;     // fill the response register and go back to root
   } dwl_ctrl_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_done;  // sweep address is at the last entry
      logic rejected;    // word in progress already fell off an edge
      logic letter_ok;   // current node and letter are inside the tables
   } dwl_stat_type;

endpackage

### rtl/core/dwl_channels.sv
// request and response channel interfaces of the word lookup block
interface dwl_req_if import dwl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [NODE_W-1:0] node;
   logic [SYM_W-1:0]  symbol;
   logic [NODE_W-1:0] next_node;
   logic              term_flag;
   logic              last_letter;

   modport source (
      output valid, cmd, node, symbol, next_node, term_flag, last_letter,
      input  ready
   );
   modport sink (
      input  valid, cmd, node, symbol, next_node, term_flag, last_letter,
      output ready
   );
endinterface

interface dwl_rsp_if;
   logic valid;
   logic ready;
   logic is_word;
   logic dead_end;

   modport source (
      output valid, is_word, dead_end,
      input  ready
   );
   modport sink (
      input  valid, is_word, dead_end,
      output ready
   );
endinterface

### rtl/core/dwl_ram.sv
// generic single write port, single read port ram with registered read
module dwl_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/dwl_ctrl.sv
// controller of the word lookup: clearing pass, beat decode and result sequencing
module dwl_ctrl import dwl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [CMD_W-1:0] req_cmd,
   input  logic             req_last,
   output logic             req_ready,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output dwl_ctrl_type     ctrl,
   input  dwl_stat_type     stat
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE_WAIT,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      last_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.clear_en = 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd_type'(req_cmd))
                  CMD_EDGE: begin
                     ctrl.edge_wr = 1'b1;
                  end
                  CMD_MARK: begin
                     ctrl.mark_wr = 1'b1;
                  end
                  CMD_LETTER: begin
                     if (!stat.rejected && stat.letter_ok) begin
                        ctrl.edge_rd = 1'b1;
                     end else begin
                        ctrl.reject  = !stat.rejected;
                        ctrl.term_rd = req_last;
                     end
                  end
                  CMD_QUERY: begin
                     ctrl.term_rd = 1'b1;
                  end
               endcase
            end
         end
         ST_EDGE_WAIT: begin
            ctrl.take_edge      = 1'b1;
            ctrl.term_rd        = last_ff;
            ctrl.term_from_edge = last_ff;
         end
         ST_FINISH: begin
            ctrl.load_result = slot_free;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.load_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_CLEAR: begin
               if (stat.clear_done) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (ctrl.edge_rd) begin
                  last_ff  <= req_last;
                  state_ff <= ST_EDGE_WAIT;
               end else if (ctrl.term_rd) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_EDGE_WAIT: begin
               state_ff <= last_ff ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
               if (ctrl.load_result) begin
                  state_ff <= ST_IDLE;
               end
            end
         endcase
      end
   end

endmodule

### rtl/core/dwl_dpath.sv
// datapath of the word lookup: edge and mark stores, walk registers, result register
module dwl_dpath import dwl_pkg::*; #(
   parameter int NODE_COUNT    = 4096,
   parameter int ALPHABET_SIZE = 27
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [NODE_W-1:0] req_node,
   input  logic [SYM_W-1:0]  req_symbol,
   input  logic [NODE_W-1:0] req_next_node,
   input  logic              req_term_flag,
   input  dwl_ctrl_type      ctrl,
   output dwl_stat_type      stat,
   output logic              rsp_is_word,
   output logic              rsp_dead_end
);

   // only nodes and letters the fields can name take storage
   localparam int NODE_SLOTS = (NODE_COUNT < NODE_LIMIT) ? NODE_COUNT : NODE_LIMIT;
   localparam int ALPH_SLOTS = (ALPHABET_SIZE < SYM_LIMIT) ? ALPHABET_SIZE : SYM_LIMIT;
   localparam int EDGE_DEPTH = NODE_SLOTS * ALPH_SLOTS;
   localparam int EA_W       = $clog2(EDGE_DEPTH);
   localparam int TA_W       = $clog2(NODE_SLOTS);

   logic [NODE_W-1:0] cur_node_ff;
   logic              rejected_ff;
   logic [EA_W-1:0]   clr_ff;
   logic              is_word_ff;
   logic              dead_end_ff;

   logic              req_node_ok;
   logic              req_sym_ok;
   logic              cur_ok;
   logic              clr_in_marks;
   logic [EA_W-1:0]   req_edge_addr;
   logic [EA_W-1:0]   cur_edge_addr;

   logic              edge_wr_en;
   logic [EA_W-1:0]   edge_wr_addr;
   logic [NODE_W-1:0] edge_wr_data;
   logic [NODE_W-1:0] edge_rd_data;
   logic              mark_wr_en;
   logic [TA_W-1:0]   mark_wr_addr;
   logic              mark_wr_data;
   logic [TA_W-1:0]   mark_rd_addr;
   logic              mark_rd_data;

   // range checks against the table sizes
   assign req_node_ok  = {1'b0, req_node} < (NODE_W + 1)'(NODE_SLOTS);
   assign cur_ok       = {1'b0, cur_node_ff} < (NODE_W + 1)'(NODE_SLOTS);
   assign req_sym_ok   = {1'b0, req_symbol} < (SYM_W + 1)'(ALPH_SLOTS);
   assign clr_in_marks = {1'b0, clr_ff} < (EA_W + 1)'(NODE_SLOTS);

   // row-major edge addresses, node times alphabet plus letter
   assign req_edge_addr = EA_W'(req_node) * EA_W'(ALPH_SLOTS) + EA_W'(req_symbol);
   assign cur_edge_addr = EA_W'(cur_node_ff) * EA_W'(ALPH_SLOTS) + EA_W'(req_symbol);

   // edge store write side, shared with the clearing pass
   assign edge_wr_en   = ctrl.clear_en || (ctrl.edge_wr && req_node_ok && req_sym_ok);
   assign edge_wr_addr = ctrl.clear_en ? clr_ff : req_edge_addr;
   assign edge_wr_data = ctrl.clear_en ? '0 : req_next_node;

   // mark store write side, shared with the clearing pass
   assign mark_wr_en   = (ctrl.clear_en && clr_in_marks) || (ctrl.mark_wr && req_node_ok);
   assign mark_wr_addr = ctrl.clear_en ? clr_ff[TA_W-1:0] : req_node[TA_W-1:0];
   assign mark_wr_data = ctrl.clear_en ? 1'b0 : req_term_flag;

   // final node comes straight from the edge just read on the last letter
   assign mark_rd_addr = ctrl.term_from_edge ? edge_rd_data[TA_W-1:0]
                                             : cur_node_ff[TA_W-1:0];

   dwl_ram #(
      .WIDTH (NODE_W),
      .DEPTH (EDGE_DEPTH)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_en   (ctrl.edge_rd),
      .rd_addr (cur_edge_addr),
      .rd_data (edge_rd_data)
   );

   dwl_ram #(
      .WIDTH (1),
      .DEPTH (NODE_SLOTS)
   ) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_wr_en),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (ctrl.term_rd),
      .rd_addr (mark_rd_addr),
      .rd_data (mark_rd_data)
   );

   // clearing sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (ctrl.clear_en && !stat.clear_done) begin
         clr_ff <= clr_ff + EA_W'(1);
      end
   end

   // walk state: current node and rejected flag
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_node_ff <= '0;
         rejected_ff <= 1'b0;
      end else if (ctrl.load_result) begin
         cur_node_ff <= '0;
         rejected_ff <= 1'b0;
      end else if (ctrl.take_edge) begin
         if (edge_rd_data != '0) begin
            cur_node_ff <= edge_rd_data;
         end else begin
            rejected_ff <= 1'b1;
         end
      end else if (ctrl.reject) begin
         rejected_ff <= 1'b1;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (ctrl.load_result) begin
         is_word_ff  <= !rejected_ff && cur_ok && mark_rd_data;
         dead_end_ff <= rejected_ff;
      end
   end

   assign stat.clear_done = (clr_ff == EA_W'(EDGE_DEPTH - 1));
   assign stat.rejected   = rejected_ff;
   assign stat.letter_ok  = cur_ok && req_sym_ok;

   assign rsp_is_word  = is_word_ff;
   assign rsp_dead_end = dead_end_ff;

endmodule

### rtl/core/dawg_word_lookup_top.sv
// top level of the dictionary word lookup on a minimal acyclic word automaton
//
// req channel: one beat per command. cmd 0 writes one transition (node, symbol,
// next_node), cmd 1 writes one terminal mark (node, term_flag), cmd 2 feeds one
// letter of a word (last_letter closes the word), cmd 3 closes the word and
// reports on it (at the root: the empty word).
// rsp channel: one beat per closed word, is_word and dead_end.
// Sequencing: a store write is done in the cycle it is accepted. A letter goes
// through ST_EDGE_WAIT for the registered read of the edge ram, whose address
// needs the node of the previous letter; a letter of an already rejected word,
// or one off the tables, skips it. A closing letter goes on to ST_FINISH, as
// does a query and a closing letter that skips the edge ram read; ST_FINISH
// loads the response register once the terminal mark ram read is done.
// One command is in flight at a time.
// Reset: a clearing pass writes zero to every edge and mark entry, one entry a
// cycle, over NODE_COUNT * ALPHABET_SIZE edge entries (110592 at the defaults,
// nodes capped at 4096 and letters at 32); req.ready stays low until it ends.
// Stalls: the response register holds its beat while rsp.ready is low; new
// commands are still taken, and a closing command waits until the register frees.
module dawg_word_lookup_top import dwl_pkg::*; #(
   parameter int NODE_COUNT    = 4096,
   parameter int ALPHABET_SIZE = 27
) (
   input logic       clock,
   input logic       reset,
   dwl_req_if.sink   req,
   dwl_rsp_if.source rsp
);

   dwl_ctrl_type ctrl;
   dwl_stat_type stat;
   logic         req_ready;
   logic         rsp_valid;
   logic         rsp_is_word;
   logic         rsp_dead_end;

   dwl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_last  (req.last_letter),
      .req_ready (req_ready),
      .rsp_ready (rsp.ready),
      .rsp_valid (rsp_valid),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   dwl_dpath #(
      .NODE_COUNT    (NODE_COUNT),
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .req_node      (req.node),
      .req_symbol    (req.symbol),
      .req_next_node (req.next_node),
      .req_term_flag (req.term_flag),
      .ctrl          (ctrl),
      .stat          (stat),
      .rsp_is_word   (rsp_is_word),
      .rsp_dead_end  (rsp_dead_end)
   );

   assign req.ready    = req_ready;
   assign rsp.valid    = rsp_valid;
   assign rsp.is_word  = rsp_is_word;
   assign rsp.dead_end = rsp_dead_end;

   // no request beat is taken during the clearing pass
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.clear_en |-> !req_ready)
      else $error("request accepted during clearing pass");

   // a result is loaded only into a free response register
   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_result |-> (!rsp_valid || rsp.ready))
      else $error("response register overwritten");

   // a loaded result shows on the response channel next cycle
   a_result_shown: assert property (@(posedge clock) disable iff (reset)
      ctrl.load_result |=> rsp_valid)
      else $error("loaded result not presented");

   // a rejected word is never reported as a word
   a_rsp_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_word && rsp_dead_end))
      else $error("response both word and dead end");

   // an edge read never overlaps a store write
   a_read_alone: assert property (@(posedge clock) disable iff (reset)
      ctrl.edge_rd |-> !(ctrl.edge_wr || ctrl.mark_wr || ctrl.clear_en))
      else $error("edge read overlaps a write");

endmodule

### test/dwl_checker.sv
// scoreboard of the word lookup: mirrors both automaton stores and checks every response beat
module dwl_checker import dwl_pkg::*; #(
   parameter int NODE_COUNT    = 4096,
   parameter int ALPHABET_SIZE = 27
) (
   input  logic clock,
   input  logic reset,
   dwl_req_if   req,
   dwl_rsp_if   rsp,
   output int   errors,
   output int   backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic is_word;
      logic dead_end;
   } verdict_type;

   // shadow of the transition store, the terminal marks and the walk in progress
   logic [NODE_W-1:0] trans [NODE_COUNT*ALPHABET_SIZE];
   bit                marks [NODE_COUNT];
   logic [NODE_W-1:0] walk_node;
   bit                walk_dead;
   verdict_type       verdicts_due [$];
   int                mismatch_count = 0;

   // end of a word: queue its verdict and go back to the root
   function automatic void close_word();
      verdict_type v;
      v.dead_end = walk_dead;
      v.is_word  = !walk_dead && ((walk_node < NODE_COUNT) ? marks[walk_node] : 1'b0);
      verdicts_due.push_back(v);
      walk_node = '0;
      walk_dead = 1'b0;
   endfunction

   // one accepted request beat through the automaton
   function automatic void advance_lookup(cmd_type c, logic [NODE_W-1:0] nd,
                                          logic [SYM_W-1:0] sy, logic [NODE_W-1:0] nx,
                                          logic tf, logic ll);
      logic [NODE_W-1:0] hop;
      case (c)
         CMD_EDGE: begin
            if (nd < NODE_COUNT && sy < ALPHABET_SIZE) trans[nd*ALPHABET_SIZE + sy] = nx;
         end
         CMD_MARK: begin
            if (nd < NODE_COUNT) marks[nd] = tf;
         end
         CMD_LETTER: begin
            // a rejected word ignores the rest of its letters
            if (!walk_dead) begin
               hop = (walk_node < NODE_COUNT && sy < ALPHABET_SIZE) ?
                     trans[walk_node*ALPHABET_SIZE + sy] : '0;
               if (hop == '0) walk_dead = 1'b1;
               else walk_node = hop;
            end
            if (ll) close_word();
         end
         default: begin
            close_word();
         end
      endcase
   endfunction

   // compare response beats first, then fold in the request beat of this edge
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (reset) begin
         foreach (trans[i]) trans[i] = '0;
         foreach (marks[i]) marks[i] = 1'b0;
         walk_node = '0;
         walk_dead = 1'b0;
         verdicts_due.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            got.is_word  = rsp.is_word;
            got.dead_end = rsp.dead_end;
            if (verdicts_due.size() == 0) begin
               $display("%0t: response beat with none expected: is_word %b dead_end %b",
                        $time, got.is_word, got.dead_end);
               mismatch_count++;
            end else begin
               want = verdicts_due.pop_front();
               if (got.is_word !== want.is_word) begin
                  $display("%0t: is_word expected %b actual %b",
                           $time, want.is_word, got.is_word);
                  mismatch_count++;
               end
               if (got.dead_end !== want.dead_end) begin
                  $display("%0t: dead_end expected %b actual %b",
                           $time, want.dead_end, got.dead_end);
                  mismatch_count++;
               end
            end
         end
         if (req.valid && req.ready)
            advance_lookup(cmd_type'(req.cmd), req.node, req.symbol, req.next_node,
                           req.term_flag, req.last_letter);
      end
      errors  <= mismatch_count;
      backlog <= verdicts_due.size();
   end

endmodule

### test/tb.sv
// testbench top of the word lookup: request stimulus, response stalls and the verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dwl_pkg::*;

   localparam int NODES   = 4096;
   localparam int LETTERS = 27;

   logic clock = 1'b0;
   logic reset;

   dwl_req_if req_ch ();
   dwl_rsp_if rsp_ch ();

   int  fail_count;
   int  verdicts_pending;
   bit  stall_mix = 1'b1;
   int  beats_sent = 0;
   // edges written so far, used only to steer words along real paths
   logic [NODE_W-1:0] known_next [int];

   dawg_word_lookup_top #(
      .NODE_COUNT    (NODES),
      .ALPHABET_SIZE (LETTERS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   dwl_checker #(
      .NODE_COUNT    (NODES),
      .ALPHABET_SIZE (LETTERS)
   ) u_checker (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .errors  (fail_count),
      .backlog (verdicts_pending)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= stall_mix ? ($urandom_range(99) >= 32) : 1'b1;
   end

   // watchdog, far beyond the clearing pass plus the slowest stimulus
   initial begin
      #6_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // one request beat, with random idle cycles ahead of it
   task automatic send_beat(cmd_type c, logic [NODE_W-1:0] nd, logic [SYM_W-1:0] sy,
                            logic [NODE_W-1:0] nx, logic tf, logic ll);
      bit taken;
      while (stall_mix && $urandom_range(99) < 32) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= c;
      req_ch.node        <= nd;
      req_ch.symbol      <= sy;
      req_ch.next_node   <= nx;
      req_ch.term_flag   <= tf;
      req_ch.last_letter <= ll;
      // ready is settled at the falling edge, the beat moves at the next rising one
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
      beats_sent++;
   endtask

   // random edge or mark write, mostly inside a small node pool and alphabet
   task automatic send_load();
      logic [NODE_W-1:0] nd;
      logic [NODE_W-1:0] nx;
      logic [SYM_W-1:0]  sy;
      int                pick;
      if ($urandom_range(99) < 85) nd = NODE_W'($urandom_range(15));
      else nd = NODE_W'($urandom);
      if ($urandom_range(99) < 70) begin
         pick = $urandom_range(99);
         if (pick < 85) sy = SYM_W'($urandom_range(7));
         else if (pick < 95) sy = SYM_W'($urandom_range(LETTERS-1));
         else sy = SYM_W'($urandom_range(31, LETTERS));
         pick = $urandom_range(99);
         if (pick < 80) nx = NODE_W'($urandom_range(15, 1));
         else if (pick < 90) nx = '0;
         else nx = NODE_W'($urandom);
         if (sy < LETTERS) known_next[int'(nd)*32 + int'(sy)] = nx;
         send_beat(CMD_EDGE, nd, sy, nx, 1'($urandom), 1'($urandom));
      end else begin
         send_beat(CMD_MARK, nd, SYM_W'($urandom), NODE_W'($urandom),
                   ($urandom_range(99) < 60), 1'($urandom));
      end
   endtask

   // random word that mostly follows known edges, closed by its last letter or a query
   task automatic send_word();
      int                len;
      int                key;
      bit                by_query;
      logic [NODE_W-1:0] at;
      logic [NODE_W-1:0] to;
      logic [SYM_W-1:0]  sy;
      logic [SYM_W-1:0]  cand;
      len      = $urandom_range(5, 1);
      by_query = ($urandom_range(9) == 0);
      at       = '0;
      for (int i = 0; i < len; i++) begin
         sy = SYM_W'($urandom_range(31));
         to = '0;
         if ($urandom_range(9) < 8) begin
            for (int k = 0; k < 8; k++) begin
               if ($urandom_range(5) == 0) cand = SYM_W'($urandom_range(LETTERS-1));
               else cand = SYM_W'($urandom_range(7));
               key = int'(at)*32 + int'(cand);
               if (known_next.exists(key) && known_next[key] != '0) begin
                  sy = cand;
                  to = known_next[key];
                  break;
               end
            end
         end
         // loads in the middle of a word
         if ($urandom_range(99) < 8) send_load();
         send_beat(CMD_LETTER, NODE_W'($urandom), sy, NODE_W'($urandom), 1'($urandom),
                   (i == len-1) && !by_query);
         if (to != '0) at = to;
      end
      if (by_query) send_beat(CMD_QUERY, NODE_W'($urandom), SYM_W'($urandom),
                              NODE_W'($urandom), 1'($urandom), 1'($urandom));
   endtask

   initial begin
      int pick;
      req_ch.valid       = 1'b0;
      req_ch.cmd         = CMD_EDGE;
      req_ch.node        = '0;
      req_ch.symbol      = '0;
      req_ch.next_node   = '0;
      req_ch.term_flag   = 1'b0;
      req_ch.last_letter = 1'b0;
      rsp_ch.ready       = 1'b0;
      reset              = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // empty dictionary, then the empty word made terminal
      send_beat(CMD_QUERY, '0, '0, '0, 1'b0, 1'b0);
      send_beat(CMD_MARK, '0, '0, '0, 1'b1, 1'b0);
      send_beat(CMD_QUERY, '1, '1, '1, 1'b1, 1'b1);

      // a path through the lowest and highest node and letter
      send_beat(CMD_EDGE, '0, 5'd0, 12'd1, 1'b0, 1'b0);
      send_beat(CMD_EDGE, 12'd1, 5'd26, '1, 1'b0, 1'b0);
      send_beat(CMD_EDGE, '1, 5'd13, 12'd2, 1'b0, 1'b0);
      send_beat(CMD_MARK, '1, '0, '0, 1'b1, 1'b0);
      send_beat(CMD_MARK, 12'd2, '0, '0, 1'b1, 1'b0);
      send_beat(CMD_LETTER, '0, 5'd0, '0, 1'b0, 1'b0);
      send_beat(CMD_LETTER, '0, 5'd26, '0, 1'b0, 1'b1);
      send_beat(CMD_LETTER, '0, 5'd0, '0, 1'b0, 1'b0);
      send_beat(CMD_LETTER, '0, 5'd26, '0, 1'b0, 1'b0);
      send_beat(CMD_LETTER, '0, 5'd13, '0, 1'b0, 1'b1);

      // letters beyond the alphabet reject, and the rest of the word is ignored
      send_beat(CMD_LETTER, '0, 5'd31, '0, 1'b0, 1'b1);
      send_beat(CMD_LETTER, '0, 5'd27, '0, 1'b0, 1'b0);
      send_beat(CMD_LETTER, '0, 5'd0, '0, 1'b0, 1'b1);

      // query in the middle of a word at a non-terminal node
      send_beat(CMD_LETTER, '0, 5'd0, '0, 1'b0, 1'b0);
      send_beat(CMD_QUERY, '0, '0, '0, 1'b0, 1'b0);

      // loads in the middle of a word
      send_beat(CMD_LETTER, '0, 5'd0, '0, 1'b0, 1'b0);
      send_beat(CMD_EDGE, 12'd1, 5'd3, 12'd7, 1'b0, 1'b0);
      send_beat(CMD_MARK, 12'd7, '0, '0, 1'b1, 1'b0);
      send_beat(CMD_LETTER, '0, 5'd3, '0, 1'b0, 1'b1);

      // edge write with a letter beyond the alphabet is dropped
      send_beat(CMD_EDGE, '0, 5'd31, 12'd9, 1'b0, 1'b0);
      send_beat(CMD_LETTER, '0, 5'd31, '0, 1'b0, 1'b1);

      // removing an edge and clearing a mark
      send_beat(CMD_EDGE, '0, 5'd0, '0, 1'b0, 1'b0);
      send_beat(CMD_LETTER, '0, 5'd0, '0, 1'b0, 1'b1);
      send_beat(CMD_MARK, '0, '0, '0, 1'b0, 1'b0);
      send_beat(CMD_QUERY, '0, '0, '0, 1'b0, 1'b0);

      // random part, with a long stretch free of idling in the middle
      while (beats_sent < 1078) begin
         stall_mix = !(beats_sent >= 400 && beats_sent < 750);
         pick = $urandom_range(99);
         if (pick < 25) send_load();
         else if (pick < 90) send_word();
         else send_beat(cmd_type'(CMD_W'($urandom_range(3))), NODE_W'($urandom),
                        SYM_W'($urandom), NODE_W'($urandom), 1'($urandom), 1'($urandom));
      end
      stall_mix = 1'b1;
      send_beat(CMD_QUERY, NODE_W'($urandom), SYM_W'($urandom), NODE_W'($urandom),
                1'($urandom), 1'($urandom));
      req_ch.valid <= 1'b0;

      // drain, then keep the clock running for anything stray
      do @(posedge clock); while (verdicts_pending != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### dawg_word_lookup_top.f
rtl/core/dwl_pkg.sv
rtl/core/dwl_channels.sv
rtl/core/dwl_ram.sv
rtl/core/dwl_ctrl.sv
rtl/core/dwl_dpath.sv
rtl/core/dawg_word_lookup_top.sv
test/dwl_checker.sv
test/tb.sv
